[design/i2c_master_byte_engine_macros.svh]
// assertion macros for the i2c master byte engine
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define IME_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ime assertion failed");

// next-cycle implication, checked out of reset
`define IME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ime assertion failed");

`else

`define IME_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define IME_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/ime_pkg.sv]
// types and constants shared by the i2c master byte engine
`default_nettype none

package ime_pkg;

    // input kind codes
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    localparam int PHASE_W = 5;
    localparam int SUB_W   = 2;

    // write: 8 bits of 3 ticks, then ack release, sample, final low
    localparam logic [PHASE_W-1:0] WR_DATA_TICKS = 5'd24;
    localparam logic [PHASE_W-1:0] WR_ACK_SAMPLE = 5'd25;
    // read: 8 bits of 2 ticks, then ack setup, ack high, final low
    localparam logic [PHASE_W-1:0] RD_DATA_TICKS = 5'd16;
    localparam logic [PHASE_W-1:0] RD_ACK_HIGH   = 5'd17;

    localparam logic [SUB_W-1:0] SUB_SETUP = 2'd0;
    localparam logic [SUB_W-1:0] SUB_HIGH  = 2'd1;
    localparam logic [SUB_W-1:0] SUB_LOW   = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_line;
    } q_item_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              push;
        logic              pop;
    } q_stat_t;

endpackage

`default_nettype wire

[design/ime_if.sv]
// handshake channels of the i2c master byte engine
`default_nettype none

interface ime_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_line;

    modport source (output valid, output kind, output data_byte, output send_ack,
                    output sda_line, input ready);
    modport sink   (input valid, input kind, input data_byte, input send_ack,
                    input sda_line, output ready);
endinterface

interface ime_out_if;
    logic       valid;
    logic       ready;
    logic       scl_high;
    logic       sda_released;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
    logic       rejected;

    modport source (output valid, output scl_high, output sda_released, output busy_res,
                    output done_res, output read_data, output ack_seen, output rejected,
                    input ready);
    modport sink   (input valid, input scl_high, input sda_released, input busy_res,
                    input done_res, input read_data, input ack_seen, input rejected,
                    output ready);
endinterface

`default_nettype wire

[design/ime_front.sv]
// front end: accepts input beats and classifies the kind code
`default_nettype none

module ime_front (
    ime_in_if.sink           in_ch,
    input  wire logic        q_ready,
    output ime_pkg::q_item_t push_item,
    output logic             push_valid
);

    ime_pkg::cmd_t cmd;

    // unknown kinds behave as plain ticks
    always_comb
    begin
        unique case (in_ch.kind)
            ime_pkg::KIND_START: cmd = ime_pkg::CMD_START;
            ime_pkg::KIND_STOP:  cmd = ime_pkg::CMD_STOP;
            ime_pkg::KIND_WRITE: cmd = ime_pkg::CMD_WRITE;
            ime_pkg::KIND_READ:  cmd = ime_pkg::CMD_READ;
            default:             cmd = ime_pkg::CMD_IDLE;
        endcase
    end

    always_comb
    begin
        push_item.cmd       = cmd;
        push_item.data_byte = in_ch.data_byte;
        push_item.send_ack  = in_ch.send_ack;
        push_item.sda_line  = in_ch.sda_line;
    end

    assign in_ch.ready = q_ready;
    assign push_valid  = in_ch.valid & q_ready;

endmodule

`default_nettype wire

[design/ime_queue.sv]
// short queue between the front end and the bus sequencer
`default_nettype none

module ime_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ime_pkg::q_item_t  push_item,
    input  wire logic              pop,
    output logic                   not_full,
    output logic                   not_empty,
    output ime_pkg::q_item_t       head_item,
    output ime_pkg::q_stat_t       stat
);

    localparam logic [ime_pkg::QCNT_W-1:0] FULL_COUNT =
        ime_pkg::QCNT_W'(ime_pkg::QUEUE_DEPTH);
    localparam logic [ime_pkg::QPTR_W-1:0] LAST_PTR =
        ime_pkg::QPTR_W'(ime_pkg::QUEUE_DEPTH - 1);

    ime_pkg::q_item_t              entry_reg [ime_pkg::QUEUE_DEPTH];
    logic [ime_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [ime_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [ime_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign not_full  = (count_reg != FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_comb
    begin
        stat.count = count_reg;
        stat.push  = push;
        stat.pop   = pop;
    end

endmodule

`default_nettype wire

[design/ime_back.sv]
// bus sequencer: runs one tick per beat and registers the result beat
`default_nettype none

module ime_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_valid,
    input  wire ime_pkg::q_item_t head_item,
    output logic                  pop,
    ime_out_if.source             out_ch
);

    ime_pkg::cmd_t                active_reg, active_next;
    logic [ime_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [ime_pkg::SUB_W-1:0]    sub_reg, sub_next;
    logic [7:0]                   shift_reg, shift_next;
    logic                         sda_out_reg, sda_out_next;
    logic                         scl_out_reg, scl_out_next;
    logic                         ack_send_reg, ack_send_next;
    logic                         ack_result_reg, ack_result_next;
    logic [7:0]                   latch_reg, latch_next;

    logic                         out_valid_reg;
    logic                         res_scl_reg, res_sda_reg, res_busy_reg, res_done_reg;
    logic                         res_rej_reg;

    // effective view of the tick after a possible command start
    logic                         start_new;
    logic                         rej;
    ime_pkg::cmd_t                eff_cmd;
    logic [ime_pkg::PHASE_W-1:0]  eff_phase;
    logic [ime_pkg::SUB_W-1:0]    eff_sub;
    logic [7:0]                   eff_shift;
    logic                         eff_ack;

    // tick outputs
    logic                         tick_scl, tick_sda, tick_done, hold_low, take_latch;
    logic [7:0]                   tick_shift;
    logic                         tick_ack_result;

    assign pop = head_valid && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        start_new = (head_item.cmd != ime_pkg::CMD_IDLE) && (active_reg == ime_pkg::CMD_IDLE);
        rej       = (head_item.cmd != ime_pkg::CMD_IDLE) && (active_reg != ime_pkg::CMD_IDLE);
        if (start_new)
        begin
            eff_cmd   = head_item.cmd;
            eff_phase = '0;
            eff_sub   = ime_pkg::SUB_SETUP;
            eff_shift = (head_item.cmd == ime_pkg::CMD_WRITE) ? head_item.data_byte : 8'h00;
            eff_ack   = head_item.send_ack;
        end
        else
        begin
            eff_cmd   = active_reg;
            eff_phase = phase_reg;
            eff_sub   = sub_reg;
            eff_shift = shift_reg;
            eff_ack   = ack_send_reg;
        end
    end

    // output logic of the sequencer
    always_comb
    begin
        tick_scl        = scl_out_reg;
        tick_sda        = sda_out_reg;
        tick_done       = 1'b0;
        hold_low        = 1'b0;
        take_latch      = 1'b0;
        tick_shift      = eff_shift;
        tick_ack_result = ack_result_reg;
        unique case (eff_cmd)
            ime_pkg::CMD_START:
            begin
                tick_scl = 1'b1;
                tick_sda = (eff_phase == '0);
                if (eff_phase != '0)
                begin
                    tick_done = 1'b1;
                    hold_low  = 1'b1;
                end
            end
            ime_pkg::CMD_STOP:
            begin
                tick_scl  = 1'b1;
                tick_sda  = (eff_phase != '0);
                tick_done = (eff_phase != '0);
            end
            ime_pkg::CMD_WRITE:
            begin
                if (eff_phase < ime_pkg::WR_DATA_TICKS)
                begin
                    if (eff_sub == ime_pkg::SUB_SETUP)
                    begin
                        tick_sda = eff_shift[7];
                    end
                    else if (eff_sub == ime_pkg::SUB_HIGH)
                    begin
                        tick_scl = 1'b1;
                    end
                    else
                    begin
                        tick_scl   = 1'b0;
                        tick_shift = {eff_shift[6:0], 1'b0};
                    end
                end
                else if (eff_phase == ime_pkg::WR_DATA_TICKS)
                begin
                    tick_sda = 1'b1;
                    tick_scl = 1'b0;
                end
                else if (eff_phase == ime_pkg::WR_ACK_SAMPLE)
                begin
                    tick_sda        = 1'b1;
                    tick_scl        = 1'b1;
                    tick_ack_result = ~head_item.sda_line;
                end
                else
                begin
                    tick_sda  = 1'b1;
                    tick_scl  = 1'b0;
                    tick_done = 1'b1;
                end
            end
            ime_pkg::CMD_READ:
            begin
                if (eff_phase < ime_pkg::RD_DATA_TICKS)
                begin
                    tick_sda = 1'b1;
                    if (!eff_phase[0])
                    begin
                        tick_scl   = 1'b1;
                        tick_shift = {eff_shift[6:0], head_item.sda_line};
                    end
                    else
                    begin
                        tick_scl = 1'b0;
                    end
                end
                else
                begin
                    tick_sda = ~eff_ack;
                    if (eff_phase == ime_pkg::RD_DATA_TICKS)
                    begin
                        tick_scl = 1'b0;
                    end
                    else if (eff_phase == ime_pkg::RD_ACK_HIGH)
                    begin
                        tick_scl = 1'b1;
                    end
                    else
                    begin
                        tick_scl   = 1'b0;
                        tick_done  = 1'b1;
                        take_latch = 1'b1;
                    end
                end
            end
            default:
            begin
                // idle: held levels shown, nothing moves
            end
        endcase
    end

    // next-state logic of the sequencer
    always_comb
    begin
        active_next     = active_reg;
        phase_next      = phase_reg;
        sub_next        = sub_reg;
        shift_next      = shift_reg;
        sda_out_next    = sda_out_reg;
        scl_out_next    = scl_out_reg;
        ack_send_next   = ack_send_reg;
        ack_result_next = ack_result_reg;
        latch_next      = latch_reg;
        if (eff_cmd != ime_pkg::CMD_IDLE)
        begin
            shift_next      = tick_shift;
            ack_send_next   = eff_ack;
            ack_result_next = tick_ack_result;
            sda_out_next    = tick_sda;
            scl_out_next    = hold_low ? 1'b0 : tick_scl;
            if (take_latch)
            begin
                latch_next = tick_shift;
            end
            if (tick_done)
            begin
                active_next = ime_pkg::CMD_IDLE;
                phase_next  = '0;
                sub_next    = ime_pkg::SUB_SETUP;
            end
            else
            begin
                active_next = eff_cmd;
                phase_next  = eff_phase + 1'b1;
                sub_next    = (eff_sub == ime_pkg::SUB_LOW) ? ime_pkg::SUB_SETUP
                                                            : eff_sub + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= ime_pkg::CMD_IDLE;
            phase_reg      <= '0;
            sub_reg        <= ime_pkg::SUB_SETUP;
            shift_reg      <= 8'h00;
            sda_out_reg    <= 1'b1;
            scl_out_reg    <= 1'b1;
            ack_send_reg   <= 1'b0;
            ack_result_reg <= 1'b0;
            latch_reg      <= 8'h00;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                active_reg     <= active_next;
                phase_reg      <= phase_next;
                sub_reg        <= sub_next;
                shift_reg      <= shift_next;
                sda_out_reg    <= sda_out_next;
                scl_out_reg    <= scl_out_next;
                ack_send_reg   <= ack_send_next;
                ack_result_reg <= ack_result_next;
                latch_reg      <= latch_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_scl_reg  <= tick_scl;
            res_sda_reg  <= tick_sda;
            res_busy_reg <= (active_next != ime_pkg::CMD_IDLE);
            res_done_reg <= tick_done;
            res_rej_reg  <= rej;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.scl_high     = res_scl_reg;
    assign out_ch.sda_released = res_sda_reg;
    assign out_ch.busy_res     = res_busy_reg;
    assign out_ch.done_res     = res_done_reg;
    assign out_ch.read_data    = latch_reg;
    assign out_ch.ack_seen     = ack_result_reg;
    assign out_ch.rejected     = res_rej_reg;

endmodule

`default_nettype wire

[design/i2c_master_byte_engine.sv]
// top level of the i2c master byte engine
`default_nettype none

// Single-master I2C byte engine driven by one tick beat per bus delay period.
// A start or stop takes 2 ticks, a write byte 27 and a read byte 19; the beat
// that carries a command is also its first tick, and a command that arrives
// while another runs is dropped and flagged as rejected. The engine takes one
// beat every cycle while the output side is not stalled and returns one result beat per
// input beat: an accepted beat is written into the two-entry queue, and the tick
// sequencer, which advances its whole bus state once per beat, registers the result
// beat into the result register behind it.
// read_data and ack_seen show the byte of the last completed read and the ack
// of the last write.

`include "i2c_master_byte_engine_macros.svh"

module i2c_master_byte_engine (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ime_in_if.sink     in_ch,
    ime_out_if.source  out_ch
);

    ime_pkg::q_item_t push_item;
    ime_pkg::q_item_t head_item;
    ime_pkg::q_stat_t q_stat;
    logic             push_valid;
    logic             q_not_full;
    logic             q_not_empty;
    logic             pop;

    ime_front u_front (
        .in_ch      (in_ch),
        .q_ready    (q_not_full),
        .push_item  (push_item),
        .push_valid (push_valid)
    );

    ime_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_item (push_item),
        .pop       (pop),
        .not_full  (q_not_full),
        .not_empty (q_not_empty),
        .head_item (head_item),
        .stat      (q_stat)
    );

    ime_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_not_empty),
        .head_item  (head_item),
        .pop        (pop),
        .out_ch     (out_ch)
    );

    `IME_ASSERT_IMPLY(a_pop_nonempty, clk, rst_n, q_stat.pop, q_stat.count != '0)
    `IME_ASSERT_IMPLY(a_push_has_room, clk, rst_n, q_stat.push, q_not_full)
    `IME_ASSERT_IMPLY(a_done_idle, clk, rst_n, out_ch.valid && out_ch.done_res, !out_ch.busy_res)
    `IME_ASSERT_NEXT(a_pop_gives_beat, clk, rst_n, pop, out_ch.valid)

endmodule

`default_nettype wire

[bench/ime_bus_monitor.sv]
// bus-level predictor and result comparison for the i2c master byte engine
`timescale 1ns / 100ps

module ime_bus_monitor (
    input  wire logic clk,
    input  wire logic rst_n,
    ime_in_if         in_mon,
    ime_out_if        out_mon,
    output int        errors,
    output int        pending,
    output int        checked,
    output int        rejects
);

    import ime_pkg::*;

    typedef struct packed {
        logic       scl_high;
        logic       sda_released;
        logic       busy;
        logic       done;
        logic [7:0] read_data;
        logic       ack_seen;
        logic       rejected;
    } bus_result_t;

    // predicted engine state
    cmd_t             active_cmd;
    logic [PHASE_W-1:0] phase;
    logic [7:0]       shifter;
    logic             sda_hold;
    logic             scl_hold;
    logic             ack_to_drive;
    logic             ack_flag;
    logic [7:0]       read_byte;

    bus_result_t      bus_q[$];

    task automatic report_mismatch(input string msg);
        begin
            errors++;
            $display("%0t ns mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string field, input logic [7:0] got,
                               input logic [7:0] want);
        begin
            if (got !== want)
            begin
                report_mismatch($sformatf("%s got %0h expected %0h (result %0d)",
                                          field, got, want, checked));
            end
        end
    endtask

    // advance the predicted bus state by one tick beat
    task automatic step_bus(input logic [2:0] kind, input logic [7:0] data,
                            input logic ack_in, input logic sda_in,
                            output bus_result_t res);
        logic       scl;
        logic       sda;
        logic       done;
        logic       rej;
        logic       hold_low;
        logic [SUB_W-1:0] sub;
        begin
            scl = scl_hold;
            sda = sda_hold;
            done = 1'b0;
            rej = 1'b0;
            hold_low = 1'b0;
            if (kind >= KIND_START && kind <= KIND_READ)
            begin
                if (active_cmd != CMD_IDLE)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    active_cmd = cmd_t'(kind);
                    phase = '0;
                    shifter = (kind == KIND_WRITE) ? data : 8'h00;
                    ack_to_drive = ack_in;
                end
            end
            if (active_cmd != CMD_IDLE)
            begin
                case (active_cmd)
                    CMD_START:
                    begin
                        scl = 1'b1;
                        sda = (phase == 0);
                        if (phase >= 1)
                        begin
                            done = 1'b1;
                            hold_low = 1'b1;
                        end
                    end
                    CMD_STOP:
                    begin
                        scl = 1'b1;
                        sda = (phase != 0);
                        if (phase >= 1)
                        begin
                            done = 1'b1;
                        end
                    end
                    CMD_WRITE:
                    begin
                        if (phase < WR_DATA_TICKS)
                        begin
                            sub = SUB_W'(phase % 3);
                            if (sub == SUB_SETUP)
                            begin
                                sda = shifter[7];
                            end
                            else if (sub == SUB_HIGH)
                            begin
                                scl = 1'b1;
                            end
                            else
                            begin
                                scl = 1'b0;
                                shifter = shifter << 1;
                            end
                        end
                        else if (phase == WR_DATA_TICKS)
                        begin
                            sda = 1'b1;
                            scl = 1'b0;
                        end
                        else if (phase == WR_ACK_SAMPLE)
                        begin
                            sda = 1'b1;
                            scl = 1'b1;
                            ack_flag = ~sda_in;
                        end
                        else
                        begin
                            sda = 1'b1;
                            scl = 1'b0;
                            done = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (phase < RD_DATA_TICKS)
                        begin
                            sda = 1'b1;
                            if (!phase[0])
                            begin
                                scl = 1'b1;
                                shifter = {shifter[6:0], sda_in};
                            end
                            else
                            begin
                                scl = 1'b0;
                            end
                        end
                        else
                        begin
                            sda = ~ack_to_drive;
                            if (phase == RD_DATA_TICKS)
                            begin
                                scl = 1'b0;
                            end
                            else if (phase == RD_ACK_HIGH)
                            begin
                                scl = 1'b1;
                            end
                            else
                            begin
                                scl = 1'b0;
                                done = 1'b1;
                                read_byte = shifter;
                            end
                        end
                    end
                endcase
                sda_hold = sda;
                // after a start the clock is parked low
                scl_hold = hold_low ? 1'b0 : scl;
                if (done)
                begin
                    active_cmd = CMD_IDLE;
                    phase = '0;
                end
                else
                begin
                    phase = phase + 1'b1;
                end
            end
            res.scl_high = scl;
            res.sda_released = sda;
            res.busy = (active_cmd != CMD_IDLE);
            res.done = done;
            res.read_data = read_byte;
            res.ack_seen = ack_flag;
            res.rejected = rej;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bus_result_t want;
        bus_result_t got;
        if (!rst_n)
        begin
            active_cmd = CMD_IDLE;
            phase = '0;
            shifter = 8'h00;
            sda_hold = 1'b1;
            scl_hold = 1'b1;
            ack_to_drive = 1'b0;
            ack_flag = 1'b0;
            read_byte = 8'h00;
            bus_q.delete();
            errors = 0;
            pending = 0;
            checked = 0;
            rejects = 0;
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
            begin
                step_bus(in_mon.kind, in_mon.data_byte, in_mon.send_ack, in_mon.sda_line,
                         want);
                bus_q.push_back(want);
                if (want.rejected)
                begin
                    rejects++;
                end
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got.scl_high = out_mon.scl_high;
                got.sda_released = out_mon.sda_released;
                got.busy = out_mon.busy_res;
                got.done = out_mon.done_res;
                got.read_data = out_mon.read_data;
                got.ack_seen = out_mon.ack_seen;
                got.rejected = out_mon.rejected;
                if (bus_q.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected");
                end
                else
                begin
                    want = bus_q.pop_front();
                    check_field("scl_high", 8'(got.scl_high), 8'(want.scl_high));
                    check_field("sda_released", 8'(got.sda_released),
                                8'(want.sda_released));
                    check_field("busy_res", 8'(got.busy), 8'(want.busy));
                    check_field("done_res", 8'(got.done), 8'(want.done));
                    check_field("read_data", got.read_data, want.read_data);
                    check_field("ack_seen", 8'(got.ack_seen), 8'(want.ack_seen));
                    check_field("rejected", 8'(got.rejected), 8'(want.rejected));
                    checked++;
                end
            end
            pending = bus_q.size();
        end
    end

endmodule

[bench/i2c_master_byte_engine_test.sv]
// stimulus and verdict for the i2c master byte engine
`timescale 1ns / 100ps

module i2c_master_byte_engine_test;

    import ime_pkg::*;

    localparam int RANDOM_BEATS = 850;
    localparam int PAUSE_AT     = 400;
    localparam int HOLD_A       = 120;
    localparam int HOLD_B       = 560;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int START_TICKS  = 2;
    localparam int STOP_TICKS   = 2;
    localparam int WRITE_TICKS  = 27;
    localparam int READ_TICKS   = 19;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycle_count = 0;
    int   sent = 0;
    int   busy_left = 0;
    logic in_burst = 1'b0;

    int   errors;
    int   pending;
    int   checked;
    int   rejects;

    ime_in_if  stim_ch ();
    ime_out_if res_ch ();

    i2c_master_byte_engine i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (stim_ch),
        .out_ch (res_ch)
    );

    ime_bus_monitor i_monitor (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_mon  (stim_ch),
        .out_mon (res_ch),
        .errors  (errors),
        .pending (pending),
        .checked (checked),
        .rejects (rejects)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // offer one beat after a random gap and wait for it to be taken
    task automatic send_beat(input logic [2:0] kind, input logic [7:0] data,
                             input logic ack, input logic sda);
        int gap;
        begin
            gap = in_burst ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                stim_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            stim_ch.kind <= kind;
            stim_ch.data_byte <= data;
            stim_ch.send_ack <= ack;
            stim_ch.sda_line <= sda;
            stim_ch.valid <= 1'b1;
            do
                @(posedge clk);
            while (!(stim_ch.valid && stim_ch.ready));
            @(negedge clk);
            sent++;
            // track the running command so random commands land when idle
            if (kind >= KIND_START && kind <= KIND_READ && busy_left == 0)
            begin
                case (kind)
                    KIND_START: busy_left = START_TICKS;
                    KIND_STOP:  busy_left = STOP_TICKS;
                    KIND_WRITE: busy_left = WRITE_TICKS;
                    default:    busy_left = READ_TICKS;
                endcase
            end
            if (busy_left > 0)
            begin
                busy_left--;
            end
        end
    endtask

    initial
    begin
        int         r;
        logic [2:0] k;
        stim_ch.valid = 1'b0;
        stim_ch.kind = KIND_TICK;
        stim_ch.data_byte = 8'h00;
        stim_ch.send_ack = 1'b0;
        stim_ch.sda_line = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // idle ticks and unknown kinds
        send_beat(KIND_TICK, 8'h00, 1'b0, 1'b0);
        send_beat(3'd5, 8'hff, 1'b1, 1'b1);
        send_beat(3'd6, 8'h00, 1'b0, 1'b0);
        send_beat(3'd7, 8'hff, 1'b1, 1'b1);
        // write with no start in front, then commands while it runs
        send_beat(KIND_WRITE, 8'hff, 1'b0, 1'b1);
        send_beat(KIND_TICK, 8'h00, 1'b1, 1'b0);
        send_beat(KIND_TICK, 8'h5a, 1'b0, 1'b1);
        send_beat(KIND_START, 8'h00, 1'b1, 1'b0);
        send_beat(KIND_STOP, 8'hff, 1'b0, 1'b1);
        send_beat(KIND_READ, 8'h00, 1'b1, 1'b0);
        send_beat(KIND_WRITE, 8'h00, 1'b0, 1'b1);
        send_beat(3'd7, 8'ha5, 1'b1, 1'b0);
        // finish the write with a nack, then a write of zeros after a start
        while (busy_left > 0)
        begin
            send_beat(KIND_TICK, 8'h00, 1'b0, 1'b1);
        end
        send_beat(KIND_START, 8'h00, 1'b0, 1'b1);
        send_beat(KIND_TICK, 8'h00, 1'b0, 1'b1);
        send_beat(KIND_WRITE, 8'h00, 1'b0, 1'b0);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 64 == 0)
            begin
                in_burst = ($urandom_range(0, 3) == 0);
            end
            if (n == PAUSE_AT)
            begin
                stim_ch.valid <= 1'b0;
                @(negedge clk);
                while (pending != 0) @(negedge clk);
            end
            r = $urandom_range(0, 99);
            if (busy_left == 0)
            begin
                if (r < 14)
                    k = KIND_START;
                else if (r < 28)
                    k = KIND_STOP;
                else if (r < 50)
                    k = KIND_WRITE;
                else if (r < 72)
                    k = KIND_READ;
                else if (r < 88)
                    k = KIND_TICK;
                else
                    k = 3'($urandom_range(KIND_READ + 1, 7));
            end
            else
            begin
                if (r < 88)
                    k = KIND_TICK;
                else if (r < 95)
                    k = 3'($urandom_range(KIND_START, KIND_READ));
                else
                    k = 3'($urandom_range(KIND_READ + 1, 7));
            end
            send_beat(k, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
        stim_ch.valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d tick and command beats, %0d commands rejected while busy",
                 sent, rejects);
        $display("%0d result beats compared field by field", checked);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // result side: random stalls, bursts, and two long hold-offs
    initial
    begin
        int   gap;
        int   beats;
        logic fast;
        res_ch.ready = 1'b0;
        beats = 0;
        fast = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (beats % 50 == 0)
            begin
                fast = ($urandom_range(0, 3) == 0);
            end
            gap = fast ? 0 : $urandom_range(0, 9);
            if (beats == HOLD_A || beats == HOLD_B)
            begin
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(res_ch.valid && res_ch.ready));
            @(negedge clk);
            beats++;
        end
    end

endmodule

[sim.f]
+incdir+design
design/ime_pkg.sv
design/ime_if.sv
design/ime_front.sv
design/ime_queue.sv
design/ime_back.sv
design/i2c_master_byte_engine.sv
bench/ime_bus_monitor.sv
bench/i2c_master_byte_engine_test.sv
